### hdl/ncl1_pkg.sv
`default_nettype none

package ncl1_pkg;

  // fixed field widths
  localparam int unsigned VAL_W      = 8;
  localparam int unsigned SUM_W      = 18;
  localparam int unsigned IMG_W      = 16;
  localparam int unsigned SLOT_W     = 4;
  localparam int unsigned POS_IN_W   = 10;
  localparam int unsigned CNT_REG_W  = 5;
  localparam int unsigned DIMS_REG_W = 11;
  localparam int unsigned CFG_DATA_W = 11;
  localparam int unsigned CFG_IDX_W  = 2;

  // default sizes of the centroid table
  localparam int unsigned DEF_MAX_CENTROIDS = 16;
  localparam int unsigned DEF_MAX_DIMS      = 1024;

  // register reset values
  localparam logic [CNT_REG_W-1:0]  COUNT_RESET = CNT_REG_W'(1);
  localparam logic [DIMS_REG_W-1:0] DIMS_RESET  = DIMS_REG_W'(784);

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_CENTROID_COUNT = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_DIMS           = CFG_IDX_W'(1);

  // request kinds
  typedef enum logic {
    KIND_LOAD  = 1'b0,
    KIND_PIXEL = 1'b1
  } kind_e;

  // control handed to each accumulator lane
  typedef struct packed {
    logic adv;   // pixel leaves the accumulate stage
    logic en;    // lane is among the centroids in use
    logic last;  // pixel closes the image
  } acc_ctrl_t;

endpackage

`default_nettype wire

### hdl/nearest_centroid_l1_assign.sv
// throughput: one request (load or pixel) per cycle while in_stall_o is low
// pipeline: the registered bank read with the accumulate stage, then the final-sum stage, form
//   the two-stage pipeline ahead of the output register, through which each result passes
// reset: asynchronous, active low; sums, pixel position and image counter clear, centroid_count
//   goes to 1 and dims to 784; the centroid table holds nothing defined until loaded
`default_nettype none

module nearest_centroid_l1_assign import ncl1_pkg::*; #(
  parameter int unsigned MAX_CENTROIDS = DEF_MAX_CENTROIDS,
  parameter int unsigned MAX_DIMS      = DEF_MAX_DIMS
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  // configuration writes
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  // request channel
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire logic                  in_kind_i,
  input  wire logic [SLOT_W-1:0]     in_centroid_slot_i,
  input  wire logic [POS_IN_W-1:0]   in_position_i,
  input  wire logic [VAL_W-1:0]      in_value_i,
  // result channel
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output logic      [IMG_W-1:0]      out_image_number_o,
  output logic      [SLOT_W-1:0]     out_nearest_o,
  output logic      [SUM_W-1:0]      out_distance_o
);

  localparam int unsigned CI_W  = (MAX_CENTROIDS > 1) ? $clog2(MAX_CENTROIDS) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_CENTROIDS + 1);
  localparam int unsigned POS_W = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
  localparam int unsigned DIM_W = $clog2(MAX_DIMS + 1);

  // configuration registers
  logic [CNT_REG_W-1:0]  count_q;
  logic [DIMS_REG_W-1:0] dims_q;
  logic [CNT_W-1:0]      used_cnt;
  logic [DIM_W-1:0]      used_dims;

  // position in the current image and image counter
  logic [POS_W-1:0] pos_q, pos_d;
  logic [DIM_W-1:0] pos_nxt;
  logic             pix_last;
  logic [IMG_W-1:0] img_q;

  // handshake
  logic in_acc, pix_acc, load_acc, load_in_table;
  logic out_ready, s2_ready, s1_ready, s1_fire, s1_close;

  // accumulate stage, fed by the bank read registers
  logic             s1_vld_q;
  logic             s1_last_q;
  logic [VAL_W-1:0] s1_pix_q;
  logic [CNT_W-1:0] s1_cnt_q;

  // final sums of a closed image
  logic             s2_vld_q;
  logic [CNT_W-1:0] s2_cnt_q;
  logic [IMG_W-1:0] s2_img_q;
  logic [SUM_W-1:0] s2_sums_q [MAX_CENTROIDS];

  // per-centroid lanes
  logic [VAL_W-1:0] elem [MAX_CENTROIDS];
  logic [SUM_W-1:0] fin  [MAX_CENTROIDS];
  acc_ctrl_t        lane_ctrl [MAX_CENTROIDS];

  // minimum search result and output register
  logic [CI_W-1:0]   best_idx;
  logic [SUM_W-1:0]  best_sum;
  logic              out_vld_q;
  logic [IMG_W-1:0]  out_img_q;
  logic [SLOT_W-1:0] out_near_q;
  logic [SUM_W-1:0]  out_dist_q;

  // clamp the registers to the table size, and a zero to 1
  always_comb begin
    if (count_q == '0) begin
      used_cnt = CNT_W'(1);
    end else if (32'(count_q) > MAX_CENTROIDS) begin
      used_cnt = CNT_W'(MAX_CENTROIDS);
    end else begin
      used_cnt = CNT_W'(count_q);
    end
    if (dims_q == '0) begin
      used_dims = DIM_W'(1);
    end else if (32'(dims_q) > MAX_DIMS) begin
      used_dims = DIM_W'(MAX_DIMS);
    end else begin
      used_dims = DIM_W'(dims_q);
    end
  end

  // elastic chain: a waiting result only blocks the stage that would close the next image
  assign out_ready  = !out_vld_q || !out_stall_i;
  assign s2_ready   = !s2_vld_q || out_ready;
  assign s1_ready   = !s1_vld_q || !s1_last_q || s2_ready;
  assign s1_fire    = s1_vld_q && s1_ready;
  assign s1_close   = s1_fire && s1_last_q;
  assign in_stall_o = !s1_ready;

  assign in_acc        = in_valid_i && !in_stall_o;
  assign pix_acc       = in_acc && (in_kind_i == KIND_PIXEL);
  assign load_acc      = in_acc && (in_kind_i == KIND_LOAD);
  assign load_in_table = 32'(in_position_i) < MAX_DIMS;

  // image ends when the next position reaches dims, and the position then wraps to zero
  assign pos_nxt  = DIM_W'(pos_q) + DIM_W'(1);
  assign pix_last = pos_nxt >= used_dims;
  assign pos_d    = pix_last ? '0 : POS_W'(pos_nxt);

  // one element bank and one accumulator per centroid, all stepping together
  for (genvar c = 0; c < MAX_CENTROIDS; c++) begin : g_cent
    logic bank_we;

    assign bank_we = load_acc && load_in_table && (32'(in_centroid_slot_i) == c);

    ncl1_bank #(
      .DEPTH (MAX_DIMS),
      .AW    (POS_W)
    ) u_bank (
      .clk_i   (clk_i),
      .we_i    (bank_we),
      .waddr_i (POS_W'(in_position_i)),
      .wdata_i (in_value_i),
      .re_i    (pix_acc),
      .raddr_i (pos_q),
      .rdata_o (elem[c])
    );

    assign lane_ctrl[c].adv  = s1_fire;
    assign lane_ctrl[c].en   = (32'(s1_cnt_q) > c);
    assign lane_ctrl[c].last = s1_last_q;

    ncl1_lane u_lane (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (lane_ctrl[c]),
      .pixel_i (s1_pix_q),
      .elem_i  (elem[c]),
      .fin_o   (fin[c])
    );

    // hold the closing sums while the minimum search runs
    always_ff @(posedge clk_i) begin
      if (s1_close) begin
        s2_sums_q[c] <= fin[c];
      end
    end
  end

  ncl1_argmin #(
    .NUM_CENT (MAX_CENTROIDS),
    .CI_W     (CI_W),
    .CNT_W    (CNT_W)
  ) u_argmin (
    .sums_i  (s2_sums_q),
    .count_i (s2_cnt_q),
    .idx_o   (best_idx),
    .sum_o   (best_sum)
  );

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= COUNT_RESET;
      dims_q    <= DIMS_RESET;
      pos_q     <= '0;
      img_q     <= '0;
      s1_vld_q  <= 1'b0;
      s2_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          CFG_CENTROID_COUNT: count_q <= cfg_data_i[CNT_REG_W-1:0];
          CFG_DIMS:           dims_q  <= cfg_data_i[DIMS_REG_W-1:0];
          default: ;
        endcase
      end
      if (pix_acc) begin
        pos_q <= pos_d;
      end
      if (s1_close) begin
        img_q <= img_q + IMG_W'(1);
      end
      if (s1_ready) begin
        s1_vld_q <= pix_acc;
      end
      if (s2_ready) begin
        s2_vld_q <= s1_close;
      end
      if (out_ready) begin
        out_vld_q <= s2_vld_q;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (pix_acc) begin
      s1_pix_q  <= in_value_i;
      s1_last_q <= pix_last;
      s1_cnt_q  <= used_cnt;
    end
    if (s1_close) begin
      s2_cnt_q <= s1_cnt_q;
      s2_img_q <= img_q;
    end
    if (s2_vld_q && out_ready) begin
      out_img_q  <= s2_img_q;
      out_near_q <= SLOT_W'(best_idx);
      out_dist_q <= best_sum;
    end
  end

  assign out_valid_o        = out_vld_q;
  assign out_image_number_o = out_img_q;
  assign out_nearest_o      = out_near_q;
  assign out_distance_o     = out_dist_q;

`ifndef SYNTHESIS
  // a closing pixel always lands in the final-sum stage
  a_close_to_s2: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_close |=> s2_vld_q)
    else $error("closing pixel did not reach final-sum stage");

  // a full final-sum stage behind a stalled result never takes another image
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_stall_i && s2_vld_q) |-> !s1_close)
    else $error("image closed over a pending result");

  // image counter steps by exactly one per closed image
  a_img_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_close |=> (img_q == $past(img_q) + IMG_W'(1)))
    else $error("image counter step wrong");

  // the result's image number trails the live counter
  a_img_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s2_vld_q && !s1_vld_q) |-> (s2_img_q != img_q))
    else $error("pending image number equals live counter");
`endif

endmodule

`default_nettype wire

### hdl/ncl1_bank.sv
`default_nettype none

module ncl1_bank import ncl1_pkg::*; #(
  parameter int unsigned DEPTH = DEF_MAX_DIMS,
  parameter int unsigned AW    = 10
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [VAL_W-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [VAL_W-1:0] rdata_o
);

  logic [VAL_W-1:0] mem_q [DEPTH];
  logic [VAL_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

### hdl/ncl1_lane.sv
`default_nettype none

module ncl1_lane import ncl1_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire acc_ctrl_t        ctrl_i,
  input  wire logic [VAL_W-1:0] pixel_i,
  input  wire logic [VAL_W-1:0] elem_i,
  output logic      [SUM_W-1:0] fin_o
);

  logic [SUM_W-1:0] sum_q, sum_d;
  logic [VAL_W-1:0] diff;
  logic [SUM_W:0]   sum_full;

  always_comb begin
    diff     = (pixel_i >= elem_i) ? (pixel_i - elem_i) : (elem_i - pixel_i);
    sum_full = {1'b0, sum_q} + (ctrl_i.en ? (SUM_W+1)'(diff) : '0);
    // saturate at the top of the sum range
    fin_o    = sum_full[SUM_W] ? '1 : sum_full[SUM_W-1:0];
    sum_d    = ctrl_i.last ? '0 : fin_o;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
    end else if (ctrl_i.adv) begin
      sum_q <= sum_d;
    end
  end

endmodule

`default_nettype wire

### hdl/ncl1_argmin.sv
`default_nettype none

module ncl1_argmin import ncl1_pkg::*; #(
  parameter int unsigned NUM_CENT = DEF_MAX_CENTROIDS,
  parameter int unsigned CI_W     = 4,
  parameter int unsigned CNT_W    = 5
) (
  input  wire logic [SUM_W-1:0] sums_i [NUM_CENT],
  input  wire logic [CNT_W-1:0] count_i,
  output logic      [CI_W-1:0]  idx_o,
  output logic      [SUM_W-1:0] sum_o
);

  localparam int unsigned LEAVES = 1 << CI_W;
  localparam int unsigned NODES  = 2 * LEAVES - 1;

  // heap order: node n has children 2n+1 and 2n+2, leaves in index order
  logic             node_v [NODES];
  logic [SUM_W-1:0] node_s [NODES];
  logic [CI_W-1:0]  node_i [NODES];

  for (genvar k = 0; k < LEAVES; k++) begin : g_leaf
    if (k < NUM_CENT) begin : g_used
      assign node_v[LEAVES-1+k] = (32'(count_i) > k);
      assign node_s[LEAVES-1+k] = sums_i[k];
    end else begin : g_pad
      assign node_v[LEAVES-1+k] = 1'b0;
      assign node_s[LEAVES-1+k] = '0;
    end
    assign node_i[LEAVES-1+k] = CI_W'(k);
  end

  for (genvar n = 0; n < LEAVES - 1; n++) begin : g_node
    logic take_r;
    // right side only on a strictly smaller sum, so lower index wins ties
    assign take_r    = node_v[2*n+2] &&
                       (!node_v[2*n+1] || (node_s[2*n+2] < node_s[2*n+1]));
    assign node_v[n] = node_v[2*n+1] | node_v[2*n+2];
    assign node_s[n] = take_r ? node_s[2*n+2] : node_s[2*n+1];
    assign node_i[n] = take_r ? node_i[2*n+2] : node_i[2*n+1];
  end

  // leaf 0 is always in use, so the root is always valid
  assign idx_o = node_v[0] ? node_i[0] : '0;
  assign sum_o = node_s[0];

endmodule

`default_nettype wire
